[hdl/lzwcl_pkg.sv]
// ----------------------------------------------------------------------------
// lzwcl_pkg
// Shared constants and types of the LZW letter compressor: default alphabet
// and dictionary sizes, output queue depth and the queue push bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwcl_pkg;

	// default dictionary shape
	localparam int unsigned ALPHABET_DEF  = 26;
	localparam int unsigned MAX_CODES_DEF = 4096;

	// input symbol width
	localparam int unsigned LETTER_W = 5;

	// output queue depth (power of two); input stalls above OQ_DEPTH-4 held
	localparam int unsigned OQ_DEPTH = 8;

	// control of the main pipeline
	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} ctl_state_t;

	// results written to the output queue in one cycle (second only with first)
	typedef struct packed {
		logic first;
		logic second;
	} oq_push_t;

endpackage

`default_nettype wire

[hdl/lzwcl_ram.sv]
// ----------------------------------------------------------------------------
// lzwcl_ram
// Generic single-write, single-read synchronous RAM with registered read
// data (read-first on an address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module lzwcl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hdl/lzwcl_out_queue.sv]
// ----------------------------------------------------------------------------
// lzwcl_out_queue
// Small output queue of results. Takes up to two results per cycle and
// gives one per cycle; the head holds while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwcl_out_queue #(
	parameter int unsigned WIDTH = 13,
	parameter int unsigned DEPTH = lzwcl_pkg::OQ_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lzwcl_pkg::oq_push_t        push,
	input  wire logic [WIDTH-1:0]           wdata0,
	input  wire logic [WIDTH-1:0]           wdata1,
	input  wire logic                       pop,
	output logic                            rd_valid,
	output logic      [WIDTH-1:0]           rd_data,
	output logic      [$clog2(DEPTH+1)-1:0] level
);

	import lzwcl_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LW-1:0]    cnt_q;
	logic [LW-1:0]    n_push;
	logic             do_pop;

	assign n_push   = LW'(push.first) + LW'(push.second);
	assign do_pop   = pop && (cnt_q != '0);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign level    = cnt_q;

	// storage, two write slots
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_ptr_q] <= wdata0;
		end
		if (push.second) begin
			mem_q[wr_ptr_q + PW'(1)] <= wdata1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + n_push - LW'(do_pop);
		end
	end

endmodule

`default_nettype wire

[hdl/lzw_compressor_letters.sv]
// ----------------------------------------------------------------------------
// lzw_compressor_letters
// LZW compressor over a small letter alphabet. The child table
// (prefix code, letter) -> code lives in one RAM; a second RAM holds, per
// code, the table index that created it, so entries left from an earlier
// message are rejected without clearing the table between messages.
//
//   channel  valid         stall         payload
//   input    letter_valid  letter_stall  letter, end_of_message
//   output   code_valid    code_stall    code, final_code
//
// A letter is taken only once the one before has left stage 1: the child RAM
// read, the code RAM read and the hit decision form a loop, since the next
// table address comes from the updated prefix. A letter passes stage 1 and
// stage 2 before its results enter the queue. After reset the child table
// is swept to zero, one entry a cycle, all MAX_CODES*ALPHABET entries
// (106496 at defaults), with letter_stall high. Results go through an 8-deep
// queue; letter_stall rises while more than 4 results are held.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_compressor_letters #(
	parameter int unsigned ALPHABET  = lzwcl_pkg::ALPHABET_DEF,
	parameter int unsigned MAX_CODES = lzwcl_pkg::MAX_CODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              letter_valid,
	output logic                                   letter_stall,
	input  wire logic [lzwcl_pkg::LETTER_W-1:0]    letter,
	input  wire logic                              end_of_message,
	output logic                                   code_valid,
	input  wire logic                              code_stall,
	output logic      [$clog2(MAX_CODES)-1:0]      code,
	output logic                                   final_code
);

	import lzwcl_pkg::*;

	localparam int unsigned CODE_W    = $clog2(MAX_CODES);
	localparam int unsigned NFC_W     = CODE_W + 1;
	localparam int unsigned TBL_DEPTH = MAX_CODES * ALPHABET;
	localparam int unsigned IDX_W     = $clog2(TBL_DEPTH);
	localparam int unsigned LVL_W     = $clog2(OQ_DEPTH + 1);
	localparam int unsigned RES_W     = CODE_W + 1;

	// control and dictionary state
	ctl_state_t        st_q;
	logic [IDX_W-1:0]  clr_q;
	logic [CODE_W-1:0] prefix_q, prefix_d, prefix_step;
	logic              pvalid_q, pvalid_d, pvalid_step;
	logic [NFC_W-1:0]  nfc_q, nfc_d;

	// stage 1: child RAM data arriving
	logic              v_s1, eom_s1, inrng_s1, fwd_s1;
	logic [CODE_W-1:0] letter_s1, fwd_code_s1;
	logic [IDX_W-1:0]  idx_s1;

	// stage 2: code RAM data arriving, decision
	logic              v_s2, eom_s2, inrng_s2;
	logic [CODE_W-1:0] letter_s2, child_s2;
	logic [IDX_W-1:0]  idx_s2;

	logic              accept, clearing, inrng_a, fwd_a, hit, add_entry;
	logic [IDX_W-1:0]  idx_a;
	logic [CODE_W-1:0] child_rdata, child_b;
	logic [IDX_W-1:0]  rev_rdata;

	logic              tbl_we;
	logic [IDX_W-1:0]  tbl_waddr;
	logic [CODE_W-1:0] tbl_wdata;

	oq_push_t          push;
	logic [RES_W-1:0]  res0, res1, q_data;
	logic [LVL_W-1:0]  q_level;

	// input handshake
	assign clearing     = (st_q == ST_CLEAR);
	assign letter_stall = (st_q != ST_RUN) || v_s1
	                      || (q_level > LVL_W'(OQ_DEPTH - 4));
	assign accept       = letter_valid && !letter_stall;

	// table address from the up-to-date prefix
	assign inrng_a = (32'(letter) < ALPHABET);
	assign idx_a   = IDX_W'(prefix_d) * IDX_W'(ALPHABET) + IDX_W'(letter);
	// entry being written this cycle is not yet in the RAM read data
	assign fwd_a   = add_entry && (idx_s2 == idx_a);

	// child table: sweep after reset, else new entries
	assign tbl_we    = clearing || add_entry;
	assign tbl_waddr = clearing ? clr_q : idx_s2;
	assign tbl_wdata = clearing ? '0 : nfc_q[CODE_W-1:0];

	lzwcl_ram #(
		.WIDTH (CODE_W),
		.DEPTH (TBL_DEPTH)
	) u_child_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (idx_a),
		.rdata (child_rdata)
	);

	// code -> creating index, checks that a child entry belongs to this message
	assign child_b = fwd_s1 ? fwd_code_s1 : child_rdata;

	lzwcl_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_CODES)
	) u_rev_ram (
		.clk   (clk),
		.we    (add_entry),
		.waddr (nfc_q[CODE_W-1:0]),
		.wdata (idx_s2),
		.raddr (child_b),
		.rdata (rev_rdata)
	);

	// hit: code assigned in this message and created from this very index
	always_comb begin
		hit = 1'b0;
		if (NFC_W'(child_s2) >= NFC_W'(ALPHABET) && NFC_W'(child_s2) < nfc_q) begin
			if (rev_rdata == idx_s2) begin
				hit = 1'b1;
			end
		end
	end

	// letter step, then end of message
	always_comb begin
		// extend, emit and add while codes remain, or start a prefix
		prefix_step = prefix_q;
		pvalid_step = pvalid_q;
		add_entry   = 1'b0;
		push.first  = 1'b0;
		res0        = {prefix_q, 1'b0};
		if (v_s2 && inrng_s2) begin
			if (!pvalid_q) begin
				prefix_step = letter_s2;
				pvalid_step = 1'b1;
			end else if (hit) begin
				prefix_step = child_s2;
			end else begin
				push.first  = 1'b1;
				add_entry   = (nfc_q < NFC_W'(MAX_CODES));
				prefix_step = letter_s2;
			end
		end

		// flush the prefix as final and clear the dictionary
		prefix_d    = prefix_step;
		pvalid_d    = pvalid_step;
		nfc_d       = add_entry ? nfc_q + NFC_W'(1) : nfc_q;
		push.second = 1'b0;
		res1        = {prefix_step, 1'b1};
		if (v_s2 && eom_s2) begin
			if (pvalid_step) begin
				if (push.first) begin
					push.second = 1'b1;
				end
			end
			prefix_d = '0;
			pvalid_d = 1'b0;
			nfc_d    = NFC_W'(ALPHABET);
		end
	end

	// a lone final result goes into the first slot
	logic             solo_final;
	logic [RES_W-1:0] slot0;
	oq_push_t         q_push;

	assign solo_final    = v_s2 && eom_s2 && pvalid_step && !push.first;
	assign q_push.first  = push.first || solo_final;
	assign q_push.second = push.second;
	assign slot0         = solo_final ? res1 : res0;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLEAR;
			clr_q    <= '0;
			prefix_q <= '0;
			pvalid_q <= 1'b0;
			nfc_q    <= NFC_W'(ALPHABET);
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(TBL_DEPTH - 1)) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					st_q <= ST_RUN;
				end
				default: begin
					st_q <= ST_CLEAR;
				end
			endcase
			prefix_q <= prefix_d;
			pvalid_q <= pvalid_d;
			nfc_q    <= nfc_d;
			v_s1     <= accept;
			v_s2     <= v_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		letter_s1   <= CODE_W'(letter);
		eom_s1      <= end_of_message;
		inrng_s1    <= inrng_a;
		idx_s1      <= idx_a;
		fwd_s1      <= fwd_a;
		fwd_code_s1 <= nfc_q[CODE_W-1:0];
		letter_s2   <= letter_s1;
		eom_s2      <= eom_s1;
		inrng_s2    <= inrng_s1;
		idx_s2      <= idx_s1;
		child_s2    <= child_b;
	end

	lzwcl_out_queue #(
		.WIDTH (RES_W),
		.DEPTH (OQ_DEPTH)
	) u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata0   (slot0),
		.wdata1   (res1),
		.pop      (!code_stall),
		.rd_valid (code_valid),
		.rd_data  (q_data),
		.level    (q_level)
	);

	assign code       = q_data[RES_W-1:1];
	assign final_code = q_data[0];

	// queue never overflows when a letter lands its results
	a_oq_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (32'(q_level) + 2 <= OQ_DEPTH))
		else $error("output queue has no room for a letter's results");

	// next free code stays within the dictionary
	a_nfc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(nfc_q) >= ALPHABET) && (32'(nfc_q) <= MAX_CODES))
		else $error("next free code out of range");

	// one letter in the lookup loop at a time
	a_one_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (v_s1 && !v_s2))
		else $error("letters overlap in the lookup loop");

endmodule

`default_nettype wire
